### design/msq_pkg.sv
// msq_pkg: shared types and constants for the mid-square probe table
// no dependencies
`timescale 1ns / 1ps
package msq_pkg;
    localparam int KEY_W = 31;
    localparam int REC_W = 32;
    localparam int SLOT_W = 7;
    localparam int SQ_W = 62;
    localparam int DIG_MAX = 19;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_SEARCH = 2'd1,
        FN_DELETE = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DELETED   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec;
    } t_req;

    // request after hashing: home value (0..99) ready for the walk
    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec;
        logic [6:0]       home;
    } t_job;

    typedef struct packed {
        logic [2:0]       status;
        logic [SLOT_W-1:0] slot;
        logic [REC_W-1:0] found_record;
    } t_res;

    typedef enum logic [2:0] {
        HS_IDLE, HS_MUL, HS_DIG, HS_LEN, HS_PICK, HS_OUT
    } t_hstate;

    typedef enum logic [2:0] {
        WS_IDLE, WS_MOD, WS_RD, WS_CHK, WS_OUT
    } t_wstate;
endpackage

### design/msq_if.sv
// msq_if: valid/ready channel carrying one payload type
// depends on nothing
`timescale 1ns / 1ps
interface msq_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/mid_square_linear_probe_table_unit.sv
// mid_square_linear_probe_table_unit: top level of the hash table
// depends on msq_pkg, msq_if, msq_hash, msq_walk, msq_ram
`timescale 1ns / 1ps
// One request in, one response out. The hash front squares the key, converts
// the square to decimal one bit a cycle, then sizes the number and picks the
// middle digits before it offers the job. The walk back end reduces the home
// value modulo SLOTS by one subtraction a cycle, then reads each slot in a read
// state and checks it in a check state through the key and record ram ports,
// and holds the response in a result state until it is taken; a one-entry
// hand-off lets the front hash the next request meanwhile.
module mid_square_linear_probe_table_unit #(
    parameter int SLOTS = 100
) (
    input  logic i_clk,
    input  logic i_rst_n,
    msq_if.sink   req,
    msq_if.source rsp
);
    import msq_pkg::*;

    t_req req_w;
    t_job job_w;
    t_res res_w;
    logic h_valid, h_ready;

    assign req_w = req.data;
    assign rsp.data = res_w;

    msq_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(req.valid), .o_ready(req.ready), .i_req(req_w),
        .o_valid(h_valid), .i_ready(h_ready), .o_job(job_w));

    msq_walk #(.SLOTS(SLOTS)) u_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(h_valid), .o_ready(h_ready), .i_job(job_w),
        .o_valid(rsp.valid), .i_ready(rsp.ready), .o_res(res_w));
endmodule

### design/msq_ram.sv
// msq_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module msq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, read returns the old word on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

### design/msq_hash.sv
// msq_hash: front part, squares the key and extracts the middle digits
// depends on msq_pkg
`timescale 1ns / 1ps
module msq_hash (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  msq_pkg::t_req      i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output msq_pkg::t_job      o_job
);
    import msq_pkg::*;
    localparam int BCD_W = DIG_MAX * 4;

    t_hstate r_state, n_state;
    t_req    r_req;
    logic [SQ_W-1:0]  r_sq;
    logic [BCD_W-1:0] r_bcd;
    logic [5:0]       r_cnt;
    logic [4:0]       r_len;
    logic [6:0]       r_home;
    logic [BCD_W-1:0] w_adj;
    logic [4:0]       w_len;
    logic [4:0]       w_p;
    logic [4:0]       w_hi_i, w_lo_i;
    logic [3:0]       w_hi_d, w_lo_d;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            HS_IDLE: if (i_valid) n_state = HS_MUL;
            HS_MUL:  n_state = HS_DIG;
            HS_DIG:  if (r_cnt == 6'(SQ_W - 1)) n_state = HS_LEN;
            HS_LEN:  n_state = HS_PICK;
            HS_PICK: n_state = HS_OUT;
            HS_OUT:  if (i_ready) n_state = HS_IDLE;
            default: n_state = HS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == HS_IDLE);
        o_valid = (r_state == HS_OUT);
        o_job.func = r_req.func;
        o_job.key  = r_req.key;
        o_job.rec  = r_req.rec;
        o_job.home = r_home;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= HS_IDLE;
        else          r_state <= n_state;
    end

    // shift-add-3 correction of every decimal digit
    always_comb begin
        for (int k = 0; k < DIG_MAX; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                       : r_bcd[4*k +: 4];
        end
    end

    // number of decimal digits, at least one
    always_comb begin
        w_len = 5'd1;
        for (int k = 1; k < DIG_MAX; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) w_len = 5'(k + 1);
        end
    end

    // digit positions: p = len/2 - 1 from the left
    assign w_p    = (r_len >> 1) - 5'd1;
    assign w_hi_i = r_len - 5'd1 - w_p;
    assign w_lo_i = r_len - 5'd2 - w_p;
    assign w_hi_d = r_bcd[{w_hi_i, 2'b00} +: 4];
    assign w_lo_d = r_bcd[{w_lo_i, 2'b00} +: 4];

    // square, then binary to decimal one bit a cycle, msb first
    always_ff @(posedge i_clk) begin
        case (r_state)
            HS_IDLE: if (i_valid) r_req <= i_req;
            HS_MUL: begin
                r_sq  <= SQ_W'(r_req.key) * SQ_W'(r_req.key);
                r_bcd <= '0;
                r_cnt <= '0;
            end
            HS_DIG: begin
                r_bcd <= {w_adj[BCD_W-2:0], r_sq[SQ_W-1]};
                r_sq  <= {r_sq[SQ_W-2:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
            end
            HS_LEN: r_len <= w_len;
            HS_PICK: begin
                if (r_len < 5'd2) r_home <= 7'(r_bcd[3:0]);
                else r_home <= 7'(w_hi_d) * 7'd10 + 7'(w_lo_d);
            end
            default: ;
        endcase
    end
endmodule

### design/msq_walk.sv
// msq_walk: back part, probes the slots and applies the operation
// depends on msq_pkg and msq_ram
`timescale 1ns / 1ps
module msq_walk #(
    parameter int SLOTS = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  msq_pkg::t_job      i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output msq_pkg::t_res      o_res
);
    import msq_pkg::*;
    localparam int AW = $clog2(SLOTS);

    t_wstate r_state, n_state;
    t_job    r_job;
    logic [SLOTS-1:0] r_vld;
    logic [6:0]  r_home;
    logic [AW-1:0] r_idx, r_start;
    t_res        r_res;
    logic        w_we;
    logic        w_red;
    logic [AW-1:0] w_nxt;
    logic [KEY_W-1:0] w_rkey;
    logic [REC_W-1:0] w_rrec;
    logic        w_cur_v, w_hit, w_end;

    msq_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key (
        .i_clk(i_clk), .i_we(w_we), .i_addr(r_idx),
        .i_wdata(r_job.key), .o_rdata(w_rkey));
    msq_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec (
        .i_clk(i_clk), .i_we(w_we), .i_addr(r_idx),
        .i_wdata(r_job.rec), .o_rdata(w_rrec));

    assign w_nxt   = (32'(r_idx) + 1 >= SLOTS) ? '0 : r_idx + AW'(1);
    assign w_cur_v = r_vld[r_idx];
    assign w_hit   = w_cur_v && (w_rkey == r_job.key);
    assign w_end   = (w_nxt == r_start);
    assign w_we    = (r_state == WS_CHK) && (r_job.func == FN_INSERT) && !w_cur_v;
    assign w_red   = (r_home >= 7'(SLOTS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            WS_IDLE: if (i_valid) n_state = WS_MOD;
            WS_MOD: begin
                if (w_red) n_state = WS_MOD;
                else n_state = (r_job.func == FN_NONE) ? WS_OUT : WS_RD;
            end
            WS_RD:   n_state = WS_CHK;
            WS_CHK: begin
                if (r_job.func == FN_INSERT) begin
                    if (!w_cur_v || w_end) n_state = WS_OUT;
                    else n_state = WS_RD;
                end else if (w_hit || !w_cur_v || w_end) n_state = WS_OUT;
                else n_state = WS_RD;
            end
            WS_OUT:  if (i_ready) n_state = WS_IDLE;
            default: n_state = WS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == WS_IDLE);
        o_valid = (r_state == WS_OUT);
        o_res   = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WS_IDLE;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (w_we) r_vld[r_idx] <= 1'b1;
            if (r_state == WS_CHK && r_job.func == FN_DELETE && w_hit)
                r_vld[r_idx] <= 1'b0;
        end
    end

    // probe walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            WS_IDLE: if (i_valid) begin
                r_job  <= i_job;
                r_home <= i_job.home;
            end
            WS_MOD: begin
                // home mod SLOTS: one subtraction of SLOTS per cycle
                if (w_red) begin
                    r_home <= r_home - 7'(SLOTS);
                end else begin
                    r_idx   <= AW'(r_home);
                    r_start <= AW'(r_home);
                end
                r_res.status <= ST_NOT_FOUND;
                r_res.slot   <= '0;
                r_res.found_record <= '0;
            end
            WS_CHK: begin
                if (r_job.func == FN_INSERT) begin
                    if (!w_cur_v) begin
                        r_res.status <= ST_INSERTED;
                        r_res.slot   <= SLOT_W'(r_idx);
                    end else if (w_end) r_res.status <= ST_FULL;
                end else if (w_hit) begin
                    r_res.status <= (r_job.func == FN_SEARCH) ? ST_FOUND : ST_DELETED;
                    r_res.slot   <= SLOT_W'(r_idx);
                    if (r_job.func == FN_SEARCH) r_res.found_record <= w_rrec;
                end
                r_idx <= w_nxt;
            end
            default: ;
        endcase
    end
endmodule
